>>> sv/imc_pkg.sv
// ----------------------------------------------------------------------------
// imc_pkg
// shared types and constants of the imu sample calibrator
// ----------------------------------------------------------------------------
package imc_pkg;

  localparam int unsigned FrameLen = 14;
  localparam int unsigned NumAxes  = 6;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [15:0] CFG_COUNT_RESET = 16'd100;
  localparam logic [16:0] GRAVITY         = 17'sd16384;
  localparam logic [15:0] TEMP_RECIP      = 16'd61681;  // ceil(2^21 / 34)
  localparam logic [11:0] TEMP_OFFSET     = 12'd365;

  typedef enum logic [1:0] {
    JOB_FRAME,
    JOB_START,
    JOB_CLEAR
  } job_kind_e;

  typedef struct packed {
    job_kind_e               kind;
    logic [15:0]             count;
    logic [5:0][15:0]        raw;
    logic [15:0]             temp_raw;
  } job_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_GRAV,
    S_LOAD
  } back_state_e;

endpackage

>>> sv/imc_if.sv
// ----------------------------------------------------------------------------
// imc_in_if / imc_out_if
// valid/ready channels of the imu sample calibrator
// ----------------------------------------------------------------------------
interface imc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [15:0] calibration_count;

  modport source (output valid, opcode, data_byte, frame_start, calibration_count,
                  input ready);
  modport sink   (input valid, opcode, data_byte, frame_start, calibration_count,
                  output ready);
endinterface

interface imc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] accel_x;
  logic signed [16:0] accel_y;
  logic signed [16:0] accel_z;
  logic signed [16:0] gyro_x;
  logic signed [16:0] gyro_y;
  logic signed [16:0] gyro_z;
  logic signed [11:0] temp_tenths;
  logic               calibrating;
  logic [15:0]        samples_remaining;
  logic               calibration_finished;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  temp_tenths, calibrating, samples_remaining, calibration_finished,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                  temp_tenths, calibrating, samples_remaining, calibration_finished,
                  output ready);
endinterface

>>> sv/imc_front.sv
// ----------------------------------------------------------------------------
// imc_front
// accepts words, assembles frames and issues jobs to the queue
// ----------------------------------------------------------------------------
module imc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  imc_in_if.sink             in_i,
  output logic               push_o,
  output imc_pkg::job_t      job_o,
  input  logic               full_i
);
  import imc_pkg::*;

  logic [15:0] cfg_q;
  logic [3:0]  pos_q, pos_d, eff;
  logic [7:0]  fb_q [FrameLen-1];
  logic        acc;

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign eff        = in_i.frame_start ? 4'd0 : pos_q;

  always_comb begin
    pos_d         = pos_q;
    push_o        = 1'b0;
    job_o.kind    = JOB_FRAME;
    job_o.count   = '0;
    job_o.temp_raw = {fb_q[6], fb_q[7]};
    for (int i = 0; i < 3; i++) begin
      job_o.raw[i] = {fb_q[2*i], fb_q[2*i+1]};
    end
    job_o.raw[3] = {fb_q[8], fb_q[9]};
    job_o.raw[4] = {fb_q[10], fb_q[11]};
    job_o.raw[5] = {fb_q[12], in_i.data_byte};
    if (acc) begin
      unique case (in_i.opcode)
        OP_DATA: begin
          if (eff == 4'(FrameLen - 1)) begin
            pos_d  = '0;
            push_o = 1'b1;
          end else begin
            pos_d = eff + 4'd1;
          end
        end
        OP_START: begin
          push_o      = 1'b1;
          job_o.kind  = JOB_START;
          job_o.count = (in_i.calibration_count != '0) ? in_i.calibration_count : cfg_q;
        end
        OP_CLEAR: begin
          push_o     = 1'b1;
          job_o.kind = JOB_CLEAR;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cfg_q <= CFG_COUNT_RESET;
    end else begin
      pos_q <= pos_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FrameLen - 1; i++) begin
      if (acc && in_i.opcode == OP_DATA && eff == 4'(i)) begin
        fb_q[i] <= in_i.data_byte;
      end
    end
  end

endmodule

>>> sv/imc_queue.sv
// ----------------------------------------------------------------------------
// imc_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module imc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  imc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output imc_pkg::job_t job_o
);
  import imc_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign job_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

>>> sv/imc_back.sv
// ----------------------------------------------------------------------------
// imc_back
// runs jobs: calibration sums, offset division and corrected output
// ----------------------------------------------------------------------------
module imc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  imc_pkg::job_t job_i,
  output logic          pop_o,
  imc_out_if.source     out_o
);
  import imc_pkg::*;

  back_state_e      state_q, state_d;
  logic [31:0]      sum_q [NumAxes];
  logic [31:0]      sum_nx [NumAxes];
  logic signed [16:0] off_q [NumAxes];
  logic [15:0]      total_q, left_q;
  logic [15:0]      raw_q [NumAxes];
  logic [31:0]      tprod_q;
  logic             tneg_q, fin_q;
  logic [2:0]       axis_q;
  logic [4:0]       bit_q;
  logic [31:0]      dvd_q, dvd_nx;
  logic [15:0]      rem_q, rem_nx;
  logic             neg_q;
  logic [16:0]      trial, diff;
  logic             qbit;
  logic [15:0]      tmag;
  logic [16:0]      a0, a1, a2;
  logic [1:0]       dom;
  logic signed [16:0] qval;
  logic [10:0]      tq;
  logic             out_free;

  assign out_free = !out_o.valid || out_o.ready;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign tmag     = job_i.temp_raw[15] ? 16'(-job_i.temp_raw) : job_i.temp_raw;

  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      sum_nx[i] = sum_q[i] + {{16{job_i.raw[i][15]}}, job_i.raw[i]};
    end
  end

  // restoring divider step
  assign trial  = {rem_q, dvd_q[31]};
  assign diff   = trial - {1'b0, total_q};
  assign qbit   = !diff[16];
  assign rem_nx = qbit ? diff[15:0] : trial[15:0];
  assign dvd_nx = {dvd_q[30:0], qbit};
  assign qval   = neg_q ? -$signed(dvd_nx[16:0]) : $signed(dvd_nx[16:0]);

  function automatic logic [16:0] mag17(logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  assign a0 = mag17(off_q[0]);
  assign a1 = mag17(off_q[1]);
  assign a2 = mag17(off_q[2]);

  always_comb begin
    priority if (a0 >= a1 && a0 >= a2) dom = 2'd0;
    else if (a1 >= a2)                 dom = 2'd1;
    else                               dom = 2'd2;
  end

  assign tq = tprod_q[31:21];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (job_i.kind == JOB_FRAME) begin
            state_d = (left_q == 16'd1) ? S_DIV : S_LOAD;
          end
        end
      end
      S_DIV:  if (bit_q == 5'd31 && axis_q == 3'(NumAxes - 1)) state_d = S_GRAV;
      S_GRAV: state_d = S_LOAD;
      S_LOAD: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      left_q      <= '0;
      fin_q       <= 1'b0;
      out_o.valid <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        sum_q[i] <= '0;
        off_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_LOAD && out_free) out_o.valid <= 1'b1;
      else if (out_o.ready)             out_o.valid <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            if (job_i.kind == JOB_FRAME) begin
              fin_q <= left_q == 16'd1;
              if (left_q != '0) begin
                left_q <= left_q - 16'd1;
                for (int i = 0; i < NumAxes; i++) sum_q[i] <= sum_nx[i];
              end
            end else begin
              total_q <= (job_i.kind == JOB_START) ? job_i.count : '0;
              left_q  <= (job_i.kind == JOB_START) ? job_i.count : '0;
              for (int i = 0; i < NumAxes; i++) begin
                sum_q[i] <= '0;
                off_q[i] <= '0;
              end
            end
          end
        end
        S_DIV: begin
          if (bit_q == 5'd31) begin
            off_q[axis_q] <= qval;
          end
        end
        S_GRAV: begin
          off_q[dom] <= off_q[dom][16] ? off_q[dom] + GRAVITY : off_q[dom] - GRAVITY;
        end
        S_LOAD: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && !empty_i) begin
      for (int i = 0; i < NumAxes; i++) raw_q[i] <= job_i.raw[i];
      tprod_q <= 32'(tmag) * 32'(TEMP_RECIP);
      tneg_q  <= job_i.temp_raw[15];
      axis_q  <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      neg_q   <= sum_nx[0][31];
      dvd_q   <= sum_nx[0][31] ? -sum_nx[0] : sum_nx[0];
    end else if (state_q == S_DIV) begin
      bit_q <= bit_q + 5'd1;
      if (bit_q == 5'd31) begin
        axis_q <= axis_q + 3'd1;
        rem_q  <= '0;
        if (axis_q != 3'(NumAxes - 1)) begin
          neg_q <= sum_q[axis_q + 3'd1][31];
          dvd_q <= sum_q[axis_q + 3'd1][31] ? -sum_q[axis_q + 3'd1]
                                            : sum_q[axis_q + 3'd1];
        end
      end else begin
        rem_q <= rem_nx;
        dvd_q <= dvd_nx;
      end
    end
    if (state_q == S_LOAD && out_free) begin
      out_o.accel_x <= $signed({raw_q[0][15], raw_q[0]}) - off_q[0];
      out_o.accel_y <= $signed({raw_q[1][15], raw_q[1]}) - off_q[1];
      out_o.accel_z <= $signed({raw_q[2][15], raw_q[2]}) - off_q[2];
      out_o.gyro_x  <= $signed({raw_q[3][15], raw_q[3]}) - off_q[3];
      out_o.gyro_y  <= $signed({raw_q[4][15], raw_q[4]}) - off_q[4];
      out_o.gyro_z  <= $signed({raw_q[5][15], raw_q[5]}) - off_q[5];
      out_o.temp_tenths <= tneg_q ? $signed(TEMP_OFFSET - {1'b0, tq})
                                  : $signed(TEMP_OFFSET + {1'b0, tq});
      out_o.calibrating          <= left_q != '0;
      out_o.samples_remaining    <= left_q;
      out_o.calibration_finished <= fin_q;
    end
  end

endmodule

>>> sv/imu_sample_calibrator_core.sv
// ----------------------------------------------------------------------------
// imu_sample_calibrator_core
// offset calibration of 14-byte accel/temperature/gyro frames
// ----------------------------------------------------------------------------
// in_i carries one word per handshake: a frame byte, a start-calibration or
// a clear-calibration command. Every 14th byte of a frame yields one word on
// out_o with corrected accel and gyro counts, temperature in tenths of a
// degree and calibration status. cfg_we_i/cfg_wdata_i set the default
// sample count used when a start command asks for zero.
// A frame byte that does not finish a frame is stored in the frame buffer.
// A finishing byte reaches out_o through the two-entry job queue, the
// back-end's idle and load states and the output register; on the last
// calibration sample the back-end runs its shared restoring divider over
// all six axes in turn and a gravity step before loading. A command passes
// the back-end's idle state alone. The front takes words while the queue
// has room, so a stalled receiver fills the output register, the back-end's
// load state, then the queue, then drops in_i.ready. Reset clears the frame
// position, sums, offsets and counts and sets the default count to 100.
// ----------------------------------------------------------------------------
module imu_sample_calibrator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  imc_in_if.sink      in_i,
  imc_out_if.source   out_o
);
  import imc_pkg::*;

  logic push, full, pop, empty;
  job_t job_in, job_out;

  imc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .push_o      (push),
    .job_o       (job_in),
    .full_i      (full)
  );

  imc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  imc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
